/* rtl/cial_pkg.sv */
// Shared constants, codes and width helpers for the card identifier allow list.
`timescale 1ns / 1ps

package cial_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int ID_W        = 40;
   localparam int INDEX_W     = 4;
   localparam int TOTAL_W     = 5;
   localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_CHECK  = 2'd0,
      OP_ADD    = 2'd1,
      OP_DELETE = 2'd2,
      OP_LIST   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_DUP       = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   // One cycle's access to the identifier table
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [ID_W-1:0]   wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

   // Wrap a position or count to the index field width
   function automatic logic [INDEX_W-1:0] to_index(input logic [COUNT_W-1:0] value);
      logic [COUNT_W+INDEX_W-1:0] wide;
      wide = {{INDEX_W{1'b0}}, value};
      return wide[INDEX_W-1:0];
   endfunction

   // Wrap a count to the total field width
   function automatic logic [TOTAL_W-1:0] to_total(input logic [COUNT_W-1:0] value);
      logic [COUNT_W+TOTAL_W-1:0] wide;
      wide = {{TOTAL_W{1'b0}}, value};
      return wide[TOTAL_W-1:0];
   endfunction

endpackage

/* rtl/cial_table.sv */
// Identifier table memory with registered read port and the shared key comparator.
`timescale 1ns / 1ps

module cial_table import cial_pkg::*; (
   input  logic              clock,
   input  mem_req_type       mem_req,
   input  logic [ID_W-1:0]   key,
   output logic [ID_W-1:0]   rd_data,
   output logic              rd_hit
);

   logic [ID_W-1:0] mem_ff [TABLE_DEPTH];
   logic [ID_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign rd_hit  = (rd_data_ff == key);

endmodule

/* rtl/card_id_allow_list.sv */
// Card identifier allow list: command sequencer walking the table one entry a cycle.
// Check, add and delete (add unless the table is full) read the stored entries in turn,
// paced by the single table read port and the one shared 40-bit comparator.
// A found delete then moves each later entry down one slot; list beats come one a cycle.
// Throughput: one command at a time; busy stays high until the final beat is issued.
// Reset (synchronous) empties the table; results cannot be stalled by the receiver.
`timescale 1ns / 1ps

module card_id_allow_list import cial_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_operation,
   input  logic [ID_W-1:0]     req_card_id,
   output logic                rsp_strobe,
   output logic [2:0]          rsp_status,
   output logic                rsp_matched,
   output logic [ID_W-1:0]     rsp_entry_id,
   output logic [INDEX_W-1:0]  rsp_entry_index,
   output logic [TOTAL_W-1:0]  rsp_entry_total,
   output logic                rsp_last
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SCAN  = 4'b0010,
      S_SHIFT = 4'b0100,
      S_LIST  = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   op_type               op_ff, op_in;
   logic [ID_W-1:0]      key_ff, key_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [COUNT_W-1:0]   iss_ff, iss_in;
   logic [COUNT_W-1:0]   idx_ff, idx_in;
   logic                 vld_ff, vld_in;

   logic                 strobe_ff, strobe_in;
   status_type           status_ff, status_in;
   logic                 matched_ff, matched_in;
   logic [ID_W-1:0]      entry_id_ff, entry_id_in;
   logic [INDEX_W-1:0]   entry_index_ff, entry_index_in;
   logic                 last_ff, last_in;

   mem_req_type          mem_req;
   logic [ID_W-1:0]      rd_data;
   logic                 rd_hit;
   logic                 hit_now;
   logic                 list_last;

   cial_table u_table (
      .clock   (clock),
      .mem_req (mem_req),
      .key     (key_ff),
      .rd_data (rd_data),
      .rd_hit  (rd_hit)
   );

   assign hit_now   = vld_ff && rd_hit;
   assign list_last = (COUNT_W'(idx_ff + 1'b1) == count_ff);

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      count_in       = count_ff;
      iss_in         = iss_ff;
      idx_in         = idx_ff;
      vld_in         = 1'b0;
      strobe_in      = 1'b0;
      status_in      = status_ff;
      matched_in     = matched_ff;
      entry_id_in    = entry_id_ff;
      entry_index_in = entry_index_ff;
      last_in        = last_ff;

      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = count_ff[ADDR_W-1:0];
      mem_req.wr_data = key_ff;
      mem_req.rd_en   = 1'b0;
      mem_req.rd_addr = iss_ff[ADDR_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in  = op_type'(req_operation);
               key_in = req_card_id;
               iss_in = '0;
               if ((op_type'(req_operation) == OP_ADD) &&
                   (count_ff == COUNT_W'(TABLE_DEPTH))) begin
                  strobe_in      = 1'b1;
                  status_in      = ST_FULL;
                  matched_in     = 1'b0;
                  entry_id_in    = '0;
                  entry_index_in = '0;
                  last_in        = 1'b1;
               end else if (op_type'(req_operation) == OP_LIST) begin
                  state_in = S_LIST;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            entry_id_in    = '0;
            entry_index_in = '0;
            matched_in     = 1'b0;
            last_in        = 1'b1;
            status_in      = ST_OK;
            if (hit_now) begin
               case (op_ff)
                  OP_CHECK: begin
                     strobe_in  = 1'b1;
                     matched_in = 1'b1;
                     state_in   = S_IDLE;
                  end
                  OP_ADD: begin
                     strobe_in = 1'b1;
                     status_in = ST_DUP;
                     state_in  = S_IDLE;
                  end
                  OP_DELETE: begin
                     // iss_ff already points one past the match
                     state_in = S_SHIFT;
                  end
                  default: begin
                     strobe_in = 1'b1;
                     state_in  = S_IDLE;
                  end
               endcase
            end else if (iss_ff == count_ff) begin
               strobe_in = 1'b1;
               state_in  = S_IDLE;
               case (op_ff)
                  OP_ADD: begin
                     mem_req.wr_en = 1'b1;
                     count_in      = COUNT_W'(count_ff + 1'b1);
                  end
                  OP_DELETE: begin
                     status_in = ST_NOT_FOUND;
                  end
                  default: begin
                     status_in = ST_OK;
                  end
               endcase
            end else begin
               mem_req.rd_en = 1'b1;
               idx_in        = iss_ff;
               iss_in        = COUNT_W'(iss_ff + 1'b1);
               vld_in        = 1'b1;
            end
         end

         S_SHIFT: begin
            // move the entry read last cycle down one slot
            if (vld_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = ADDR_W'(idx_ff - 1'b1);
               mem_req.wr_data = rd_data;
            end
            if (iss_ff == count_ff) begin
               count_in       = COUNT_W'(count_ff - 1'b1);
               strobe_in      = 1'b1;
               status_in      = ST_OK;
               matched_in     = 1'b0;
               entry_id_in    = '0;
               entry_index_in = '0;
               last_in        = 1'b1;
               state_in       = S_IDLE;
            end else begin
               mem_req.rd_en = 1'b1;
               idx_in        = iss_ff;
               iss_in        = COUNT_W'(iss_ff + 1'b1);
               vld_in        = 1'b1;
            end
         end

         S_LIST: begin
            if (vld_ff) begin
               strobe_in      = 1'b1;
               status_in      = ST_OK;
               matched_in     = 1'b0;
               entry_id_in    = rd_data;
               entry_index_in = to_index(idx_ff);
               last_in        = list_last;
               if (list_last) begin
                  state_in = S_IDLE;
               end
            end
            if (iss_ff < count_ff) begin
               mem_req.rd_en = 1'b1;
               idx_in        = iss_ff;
               iss_in        = COUNT_W'(iss_ff + 1'b1);
               vld_in        = 1'b1;
            end else if (!vld_ff) begin
               // nothing stored: single empty beat
               strobe_in      = 1'b1;
               status_in      = ST_EMPTY;
               matched_in     = 1'b0;
               entry_id_in    = '0;
               entry_index_in = '0;
               last_in        = 1'b1;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         vld_ff    <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         vld_ff    <= vld_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      iss_ff         <= iss_in;
      idx_ff         <= idx_in;
      status_ff      <= status_in;
      matched_ff     <= matched_in;
      entry_id_ff    <= entry_id_in;
      entry_index_ff <= entry_index_in;
      last_ff        <= last_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_matched     = matched_ff;
   assign rsp_entry_id    = entry_id_ff;
   assign rsp_entry_index = entry_index_ff;
   assign rsp_entry_total = to_total(count_ff);
   assign rsp_last        = last_ff;

endmodule
